[rtl/core/bpa_pkg.sv]
// Package for the bitmap page allocator: opcodes, status codes, register indexes, states.
package bpa_pkg;
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_INIT  = 3'd1,
    ST_NO_PAGE  = 3'd2,
    ST_BAD_ADDR = 3'd3,
    ST_NOT_USED = 3'd4
  } status_t;

  localparam logic [1:0] REG_HEAP_BASE   = 2'd0;
  localparam logic [1:0] REG_HEAP_LIMIT  = 2'd1;
  localparam logic [1:0] REG_RSV_BASE    = 2'd2;
  localparam logic [1:0] REG_RSV_LENGTH  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_SIZE,
    S_INIT_RSV,
    S_INIT_CLEAR,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } state_t;
endpackage

[rtl/core/bitmap_page_allocator.sv]
// Bitmap page allocator: next-fit page-frame allocation over a bitmap memory.
// Alloc scans bitmap words from the hint until a free page is found; free reads and
// updates one word; init sizes the heap, marks the reserve range and clears each bitmap
// word (MAX_PAGES/WORD_BITS) in turn. No-op and calls before init go straight to the result.
// The output register holds a result while the next word is accepted.
// Reset (rst_n, synchronous) clears control state; the bitmap is cleared by init.
module bitmap_page_allocator #(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_SHIFT = 12,
  parameter int WORD_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op[1:0], page_address[33:2], zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[2:0], granted_address[34:3], reserved_count[47:35]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import bpa_pkg::*;

  localparam int NWORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BW     = $clog2(WORD_BITS);
  localparam int PW     = $clog2(MAX_PAGES + 1);
  localparam int IW     = AW + BW;
  localparam int CW     = 13;
  localparam logic [33:0] PGMASK = (34'd1 << PAGE_SHIFT) - 34'd1;

  logic [31:0] heap_base_r, heap_limit_r, rsv_base_r, rsv_len_r;
  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;

  state_t state_r, state_nxt;
  logic        ready_r, ready_nxt;
  logic [PW-1:0] hint_r, hint_nxt, pages_r, pages_nxt;
  logic [CW-1:0] rsv_tot_r, rsv_tot_nxt;
  logic [32:0] start_r, start_nxt;
  logic [PW:0] rs_r, rs_nxt, re_r, re_nxt;
  logic [IW:0] idx_r, idx_nxt;
  logic [31:0] addr_r;
  logic        out_v_r, out_v_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [31:0] gr_r, gr_nxt;
  logic [2:0]  out_st_r, out_st_nxt;
  logic [31:0] out_gr_r, out_gr_nxt;
  logic [CW-1:0] out_rsv_r, out_rsv_nxt;

  // Free-bit search in the word just read, at or above a starting bit; the lowest free bit wins.
  logic [WORD_BITS-1:0] cand;
  logic        found;
  logic [BW-1:0] fbit;
  always_comb begin
    cand = ~rdata_r & ({WORD_BITS{1'b1}} << idx_r[BW-1:0]);
    found = 1'b0;
    fbit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        found = 1'b1;
        fbit = BW'(b);
      end
    end
  end

  // Sizing arithmetic on the configured bounds.
  logic [32:0] raw_pg, bytes, st_calc, pg_calc, rend, rsa, rea, mend;
  always_comb begin
    raw_pg = (heap_limit_r > heap_base_r) ?
             33'((heap_limit_r - heap_base_r) >> PAGE_SHIFT) : 33'd0;
    bytes = (raw_pg + 33'd7) >> 3;
    st_calc = 33'(((34'(heap_base_r) + 34'(bytes) + PGMASK) & ~PGMASK));
    pg_calc = (st_calc < {1'b0, heap_limit_r}) ?
              (({1'b0, heap_limit_r} - st_calc) >> PAGE_SHIFT) : 33'd0;
    rend = 33'(rsv_base_r) + 33'(rsv_len_r);
    rsa  = 33'(rsv_base_r) & ~PGMASK[32:0];
    rea  = 33'((34'(rend) + PGMASK) & ~PGMASK);
    mend = start_r + (33'(pages_r) << PAGE_SHIFT);
  end

  logic [32:0] fdiff;
  logic [IW:0] cur_pg;
  always_comb begin
    fdiff = {1'b0, addr_r} - start_r;
    cur_pg = {idx_r[IW:BW], fbit};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ready_r <= 1'b0; hint_r <= '0; pages_r <= '0;
      rsv_tot_r <= '0; start_r <= '0; out_v_r <= 1'b0;
      heap_base_r <= '0; heap_limit_r <= '0; rsv_base_r <= '0; rsv_len_r <= '0;
    end else begin
      state_r <= state_nxt; ready_r <= ready_nxt; hint_r <= hint_nxt;
      pages_r <= pages_nxt; rsv_tot_r <= rsv_tot_nxt; start_r <= start_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HEAP_BASE:  heap_base_r  <= cfg_wdata;
          REG_HEAP_LIMIT: heap_limit_r <= cfg_wdata;
          REG_RSV_BASE:   rsv_base_r   <= cfg_wdata;
          REG_RSV_LENGTH: rsv_len_r    <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rs_r <= rs_nxt; re_r <= re_nxt; idx_r <= idx_nxt; st_r <= st_nxt; gr_r <= gr_nxt;
    out_st_r <= out_st_nxt; out_gr_r <= out_gr_nxt; out_rsv_r <= out_rsv_nxt;
    if (in_tvalid && in_tready) begin
      addr_r <= in_tdata[33:2];
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata = {out_rsv_r, out_gr_r, out_st_r};

  always_comb begin
    state_nxt = state_r; ready_nxt = ready_r; hint_nxt = hint_r; pages_nxt = pages_r;
    rsv_tot_nxt = rsv_tot_r; start_nxt = start_r; rs_nxt = rs_r; re_nxt = re_r;
    idx_nxt = idx_r; st_nxt = st_r; gr_nxt = gr_r;
    out_st_nxt = out_st_r; out_gr_nxt = out_gr_r; out_rsv_nxt = out_rsv_r;
    out_v_nxt = out_v_r && !out_tready;
    mem_we = 1'b0; mem_addr = idx_r[IW-1:BW]; mem_wdata = rdata_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          st_nxt = ST_OK; gr_nxt = '0;
          unique case (op_t'(in_tdata[1:0]))
            OP_INIT:  state_nxt = S_INIT_SIZE;
            OP_ALLOC: begin
              if (!ready_r) begin st_nxt = ST_NO_INIT; state_nxt = S_DONE; end
              else begin idx_nxt = (IW+1)'(hint_r); state_nxt = S_ALLOC_RD; end
            end
            OP_FREE: begin
              if (!ready_r) begin st_nxt = ST_NO_INIT; state_nxt = S_DONE; end
              else state_nxt = S_FREE_RD;
            end
            OP_NOP: state_nxt = S_DONE;
          endcase
        end
      end
      S_INIT_SIZE: begin
        start_nxt = st_calc;
        pages_nxt = (pg_calc > 33'(MAX_PAGES)) ? PW'(MAX_PAGES) : PW'(pg_calc);
        hint_nxt = '0; idx_nxt = '0; state_nxt = S_INIT_RSV;
      end
      S_INIT_RSV: begin
        // Page range of the reserve, clipped to the managed region.
        rs_nxt = '0; re_nxt = '0;
        if (rsv_base_r != 0 && rsv_len_r != 0 && !rend[32] | (rend == 33'h1_0000_0000)) begin
          if (rsa >= mend) rs_nxt = (PW+1)'(pages_r);
          else if (rsa >= start_r) rs_nxt = (PW+1)'((rsa - start_r) >> PAGE_SHIFT);
          if (rea > mend) re_nxt = (PW+1)'(pages_r);
          else if (rea > start_r) re_nxt = (PW+1)'((rea - start_r) >> PAGE_SHIFT);
        end
        state_nxt = S_INIT_CLEAR;
      end
      S_INIT_CLEAR: begin
        mem_we = 1'b1;
        for (int b = 0; b < WORD_BITS; b++) begin
          mem_wdata[b] = ((PW+1)'({idx_r[IW-1:BW], BW'(b)}) >= rs_r) &&
                         ((PW+1)'({idx_r[IW-1:BW], BW'(b)}) < re_r);
        end
        idx_nxt = idx_r + (IW+1)'(WORD_BITS);
        if (idx_r[IW-1:BW] == AW'(NWORDS - 1)) begin
          rsv_tot_nxt = (re_r > rs_r) ? CW'(re_r - rs_r) : '0;
          ready_nxt = 1'b1; state_nxt = S_DONE;
        end
      end
      S_ALLOC_RD: begin
        if ((PW+1)'(idx_r) >= (PW+1)'(pages_r)) begin
          st_nxt = ST_NO_PAGE; state_nxt = S_DONE;
        end else state_nxt = S_ALLOC_CHK;
      end
      S_ALLOC_CHK: begin
        if (found && (PW+1)'(cur_pg) < (PW+1)'(pages_r)) begin
          mem_we = 1'b1; mem_wdata = rdata_r | (WORD_BITS'(1) << fbit);
          hint_nxt = PW'(cur_pg + 1'b1);
          gr_nxt = 32'(start_r + (33'(cur_pg) << PAGE_SHIFT));
          state_nxt = S_DONE;
        end else if (found) begin
          st_nxt = ST_NO_PAGE; state_nxt = S_DONE;
        end else begin
          idx_nxt = {idx_r[IW:BW] + 1'b1, BW'(0)};
          state_nxt = S_ALLOC_RD;
        end
      end
      S_FREE_RD: begin
        idx_nxt = (IW+1)'(fdiff >> PAGE_SHIFT);
        // Read the word that holds the page now, so it is ready in the check cycle.
        mem_addr = idx_nxt[IW-1:BW];
        if (addr_r == 0 || {1'b0, addr_r} < start_r || (addr_r & PGMASK[31:0]) != 0 ||
            (fdiff >> PAGE_SHIFT) >= 33'(pages_r)) begin
          st_nxt = ST_BAD_ADDR; state_nxt = S_DONE;
        end else state_nxt = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (!rdata_r[idx_r[BW-1:0]]) st_nxt = ST_NOT_USED;
        else begin
          mem_we = 1'b1; mem_wdata = rdata_r & ~(WORD_BITS'(1) << idx_r[BW-1:0]);
          if (PW'(idx_r) < hint_r) hint_nxt = PW'(idx_r);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Wait here while the previous result is still held at the output.
        if (!out_v_r || out_tready) begin
          out_v_nxt = 1'b1; out_st_nxt = st_r; out_gr_nxt = gr_r; out_rsv_nxt = rsv_tot_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("input taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |=> $stable(out_tdata)) else $error("result changed");
  a_hint: assert property (@(posedge clk) disable iff (!rst_n)
    hint_r <= pages_r) else $error("hint beyond region");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ready_r) |-> $past(state_r) == S_INIT_CLEAR) else $error("ready without init");
endmodule

[verif/tb_bitmap_page_allocator.sv]
// Testbench for the bitmap page allocator: directed table, then random traffic checked against a predictor.
`timescale 1ns / 100ps

module tb_bitmap_page_allocator;
  import bpa_pkg::*;

  localparam int PAGES_MAX = 4096;
  localparam int PSHIFT = 12;
  localparam longint PSIZE = 64'd1 << PSHIFT;
  localparam longint PMASK = PSIZE - 1;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DIR_ROWS = 20;
  localparam int RAND_ITEMS = 1100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;   // op[1:0], page_address[33:2], zeros
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;       // status[2:0], granted_address[34:3], reserved_count[47:35]
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  bitmap_page_allocator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    status_t status;
    logic [31:0] granted;
    logic [12:0] rsv_count;
  } alloc_result_t;

  // Predictor state.
  logic [63:0] heap_base_q, heap_limit_q, rsv_base_q, rsv_len_q;
  bit page_used [PAGES_MAX];
  int unsigned hint_q, rsv_total_q, reg_pages_q;
  logic [63:0] reg_start_q;
  bit ready_q;

  alloc_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 13;
  // Pages handed out, so frees can target real allocations.
  logic [31:0] granted_pages[$];

  typedef struct {
    op_t op;
    logic [31:0] addr;
    bit has_exp;
    status_t exp_status;
  } dir_row_t;

  function automatic alloc_result_t predict_allocator(op_t op, logic [31:0] addr);
    alloc_result_t r;
    longint unsigned raw, bytes, start, pages, rend, rs, re, mend, idx;
    r.status = ST_OK;
    r.granted = '0;
    if (op == OP_INIT) begin
      raw = 0;
      pages = 0;
      if (heap_limit_q > heap_base_q) raw = (heap_limit_q - heap_base_q) >> PSHIFT;
      bytes = (raw + 7) / 8;
      start = (heap_base_q + bytes + PMASK) & ~PMASK;
      if (start < heap_limit_q) pages = (heap_limit_q - start) >> PSHIFT;
      if (pages > PAGES_MAX) pages = PAGES_MAX;
      reg_start_q = start;
      reg_pages_q = 32'(pages);
      foreach (page_used[i]) page_used[i] = 0;
      hint_q = 0;
      rsv_total_q = 0;
      if (rsv_base_q != 0 && rsv_len_q != 0) begin
        rend = rsv_base_q + rsv_len_q;
        if (rend <= 64'h1_0000_0000) begin
          rs = rsv_base_q & ~PMASK;
          re = (rend + PMASK) & ~PMASK;
          mend = start + (pages << PSHIFT);
          if (rs < start) rs = start;
          if (re > mend) re = mend;
          if (rs < re) begin
            for (longint unsigned i = (rs - start) >> PSHIFT; i < ((re - start) >> PSHIFT); i++) begin
              page_used[i] = 1;
              rsv_total_q++;
            end
          end
        end
      end
      ready_q = 1;
    end else if (op == OP_ALLOC) begin
      if (!ready_q) begin
        r.status = ST_NO_INIT;
      end else begin
        r.status = ST_NO_PAGE;
        for (int unsigned i = hint_q; i < reg_pages_q; i++) begin
          if (!page_used[i]) begin
            page_used[i] = 1;
            hint_q = i + 1;
            r.granted = 32'(reg_start_q + (64'(i) << PSHIFT));
            r.status = ST_OK;
            break;
          end
        end
      end
    end else if (op == OP_FREE) begin
      if (!ready_q) begin
        r.status = ST_NO_INIT;
      end else if (addr == 0 || 64'(addr) < reg_start_q || (addr & 32'(PMASK)) != 0) begin
        r.status = ST_BAD_ADDR;
      end else begin
        idx = (64'(addr) - reg_start_q) >> PSHIFT;
        if (idx >= reg_pages_q) begin
          r.status = ST_BAD_ADDR;
        end else if (!page_used[idx]) begin
          r.status = ST_NOT_USED;
        end else begin
          page_used[idx] = 0;
          if (idx < hint_q) hint_q = 32'(idx);
        end
      end
    end
    r.rsv_count = 13'(rsv_total_q);
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result checker and sink-side stalling.
  always @(posedge clk) begin
    alloc_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[47:0];
      got.status = status_t'(out_tdata[2:0]);
      got.granted = out_tdata[34:3];
      got.rsv_count = out_tdata[47:35];
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: %h", out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status || got.granted != want.granted ||
            got.rsv_count != want.rsv_count) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp status %0d addr %h rsv %0d, got status %0d addr %h rsv %0d",
                     want.status, want.granted, want.rsv_count,
                     got.status, got.granted, got.rsv_count);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Writes one register; the caller drops the write enable after the last write.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_HEAP_BASE:  heap_base_q = 64'(val);
      REG_HEAP_LIMIT: heap_limit_q = 64'(val);
      REG_RSV_BASE:   rsv_base_q = 64'(val);
      default:        rsv_len_q = 64'(val);
    endcase
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 + PAGES_MAX / 32 * 2 + 20) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] hb, logic [31:0] hl, logic [31:0] rb, logic [31:0] rl);
    drain_results();
    write_reg(REG_HEAP_BASE, hb);
    write_reg(REG_HEAP_LIMIT, hl);
    write_reg(REG_RSV_BASE, rb);
    write_reg(REG_RSV_LENGTH, rl);
    cfg_we <= 1'b0;
  endtask

  // Drives one word; in_tvalid stays high across back-to-back words.
  task automatic send_word(op_t op, logic [31:0] addr);
    alloc_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, addr, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_allocator(op, addr);
    if (op == OP_ALLOC && r.status == ST_OK) granted_pages.push_back(r.granted);
    pending_results.push_back(r);
  endtask

  task automatic release_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_free_addr();
    int k;
    logic [31:0] a;
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'(reg_start_q) + ($urandom_range(40) << PSHIFT) + $urandom_range(1, 4095);
      2: return 32'(reg_start_q) + ($urandom_range(60) << PSHIFT);
      default: begin
        if (granted_pages.size() == 0) return 32'(reg_start_q);
        k = $urandom_range(granted_pages.size() - 1);
        a = granted_pages[k];
        granted_pages.delete(k);
        return a;
      end
    endcase
  endfunction

  task automatic random_phase(int n);
    op_t op;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 55) op = OP_ALLOC;
      else if (sel < 96) op = OP_FREE;
      else if (sel < 98) op = OP_INIT;
      else op = OP_NOP;
      if (op == OP_INIT) granted_pages.delete();
      send_word(op, (op == OP_FREE) ? pick_free_addr() : $urandom());
    end
    release_input();
  endtask

  initial begin
    dir_row_t rows[DIR_ROWS];
    alloc_result_t exp_r;
    heap_base_q = 0; heap_limit_q = 0; rsv_base_q = 0; rsv_len_q = 0;
    reg_start_q = 0; reg_pages_q = 0; hint_q = 0; rsv_total_q = 0; ready_q = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Before init, then an empty heap, then small heap with reserve.
    rows = '{
      '{OP_ALLOC, 32'h0,          1, ST_NO_INIT},
      '{OP_FREE,  32'h0010_0000,  1, ST_NO_INIT},
      '{OP_NOP,   32'hFFFF_FFFF,  1, ST_OK},
      '{OP_INIT,  32'h0,          1, ST_OK},
      '{OP_ALLOC, 32'h0,          1, ST_NO_PAGE},
      '{OP_FREE,  32'h0,          1, ST_BAD_ADDR},
      '{OP_FREE,  32'hFFFF_F000,  1, ST_BAD_ADDR},
      '{OP_NOP,   32'h0,          1, ST_OK},
      '{OP_ALLOC, 32'h0,          1, ST_NO_PAGE},
      '{OP_FREE,  32'h0000_1000,  1, ST_BAD_ADDR},
      '{OP_INIT,  32'h0,          0, ST_OK},
      '{OP_ALLOC, 32'h0,          0, ST_OK},
      '{OP_ALLOC, 32'h0,          0, ST_OK},
      '{OP_FREE,  32'h0,          1, ST_BAD_ADDR},
      '{OP_ALLOC, 32'h0,          0, ST_OK},
      '{OP_ALLOC, 32'h0,          0, ST_OK},
      '{OP_ALLOC, 32'h0,          0, ST_OK},
      '{OP_ALLOC, 32'h0,          0, ST_OK},
      '{OP_ALLOC, 32'h0,          0, ST_OK},
      '{OP_INIT,  32'h0,          0, ST_OK}
    };
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == 10) begin
        release_input();
        // Small heap of 8 pages with a partial reserve clipped at the start.
        configure(32'h0001_0000, 32'h0001_9000, 32'h0000_8000, 32'h0000_9800);
      end
      send_word(rows[i].op, rows[i].addr);
      exp_r = pending_results[$];
      if (rows[i].has_exp && exp_r.status != rows[i].exp_status) begin
        errors++;
        if (errors <= 10) $display("directed row %0d: predictor disagrees with table", i);
      end
    end
    release_input();

    // The sender holds off until everything has come back.
    drain_results();

    // Inverted heap, no reserve length.
    configure(32'hFFFF_F000, 32'h0000_1000, 32'h1234_5000, 32'h0);
    random_phase(40);

    // Maximal heap: saturates at the page limit, reserve runs to the top of memory.
    configure(32'h0, 32'hFFFF_FFFF, 32'hFFFF_F001, 32'h0000_0FFF);
    random_phase(60);

    // Reserve end past 2^32 marks nothing.
    configure(32'h8000_0000, 32'h8004_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_INIT, 32'h0);
    random_phase(150);

    // Mid-size heap with reserve inside; a long stretch with no idling.
    configure(32'h0040_0123, 32'h0048_0000, 32'h0040_3000, 32'h0000_5001);
    send_word(OP_INIT, 32'h0);
    idle_pct = 0;
    random_phase(300);
    idle_pct = 13;
    random_phase(250);

    // Small heap, many random ops.
    configure(32'h1000_0000, 32'h1000_F000, 32'h0, 32'h0000_2000);
    send_word(OP_INIT, 32'h0);
    random_phase(300);

    drain_results();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
